FILE: hdl/fcs_pkg.sv
`default_nettype none
// ============================================================================
// fcs_pkg
// Shared types and constants for the FIFO counting semaphore: the request
// and response word formats, status codes and controller command bundle.
// ============================================================================
package fcs_pkg;

    // Number of entries in the wait queue.
    localparam int QUEUE_DEPTH = 16;
    // Number of requester id bits that are kept.
    localparam int ID_BITS = 8;

    // Width of the queue fill count (0..QUEUE_DEPTH).
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Command codes.
    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_CANCEL  = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_GRANTED     = 3'd0;
    localparam logic [2:0] ST_QUEUED      = 3'd1;
    localparam logic [2:0] ST_FULL        = 3'd2;
    localparam logic [2:0] ST_RELEASED    = 3'd3;
    localparam logic [2:0] ST_CANCELLED   = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd5;
    localparam logic [2:0] ST_BAD_RELEASE = 3'd6;

    // Request word.
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] requester_id;
    } req_t;

    // Response word.
    typedef struct packed {
        logic [2:0] status;
        logic       waiter_granted;
        logic [7:0] waiter_id;
        logic [7:0] slots_in_use;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/fifo_counting_semaphore.sv
`default_nettype none
// ============================================================================
// fifo_counting_semaphore
// Counting semaphore with a FIFO wait queue of waiting requester ids.
// ============================================================================
// Each request word is captured, with its id compared against all queue entries
// in parallel, and then committed into the counter, the queue and the response
// register. A new word is accepted while the previous response waits to be taken;
// the block only holds in its commit cycle while the response register is still
// full and stalled. Queue entries are kept compacted, so a cancel or a grant
// closes the gap in the same commit cycle. The slot limit resets to one and
// may be rewritten only while the block is idle.
module fifo_counting_semaphore (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire fcs_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output fcs_pkg::rsp_t      rsp,
    input  wire logic          cfg_we,
    input  wire logic [7:0]    cfg_data
);
    import fcs_pkg::*;

    ctrl_cmd_t cmd;

    // Sequencing of capture and commit.
    fcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // Counter, queue and response storage.
    fcs_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .rsp      (rsp)
    );

endmodule
`default_nettype wire

FILE: hdl/fcs_ctrl.sv
`default_nettype none
// ============================================================================
// fcs_ctrl
// Controller for the semaphore. It accepts a request word, lets the datapath
// capture it with its id compared against the queue, then commits the operation
// once the response register is free to take the result.
// ============================================================================
module fcs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output fcs_pkg::ctrl_cmd_t      cmd
);
    import fcs_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic out_free;

    // The response register can take a new word when empty or being drained.
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Next-state and command logic.
    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and response valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

FILE: hdl/fcs_datapath.sv
`default_nettype none
// ============================================================================
// fcs_datapath
// Datapath for the semaphore: slot counter, slot limit register, the
// compacting wait queue with per-entry id compare, and the response register.
// ============================================================================
module fcs_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fcs_pkg::ctrl_cmd_t cmd,
    input  wire fcs_pkg::req_t      req,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_data,
    output fcs_pkg::rsp_t           rsp
);
    import fcs_pkg::*;

    logic [7:0]             max_slots_reg;
    logic [7:0]             used_reg;
    logic [7:0]             used_next;
    logic [CNT_W-1:0]       wcount_reg;
    logic [CNT_W-1:0]       wcount_next;
    logic [ID_BITS-1:0]     queue_reg [QUEUE_DEPTH];
    logic [ID_BITS-1:0]     queue_next [QUEUE_DEPTH];
    logic [1:0]             op_reg;
    logic [ID_BITS-1:0]     id_reg;
    logic [QUEUE_DEPTH-1:0] match_reg;
    logic [QUEUE_DEPTH-1:0] match_now;
    logic [QUEUE_DEPTH-2:0] shift_en;
    logic                   found;
    logic [7:0]             used_dec;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;

    // Per-entry compare of the incoming id against the live part of the queue.
    always_comb
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            match_now[k] = (CNT_W'(k) < wcount_reg) &&
                           (queue_reg[k] == ID_BITS'(req.requester_id));
        end
    end

    // Capture the request and its match vector.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= req.command;
            id_reg    <= ID_BITS'(req.requester_id);
            match_reg <= match_now;
        end
    end

    assign found    = |match_reg;
    assign used_dec = used_reg - 8'd1;

    // Operation logic: counter, queue updates and response word.
    always_comb
    begin
        used_next   = used_reg;
        wcount_next = wcount_reg;
        shift_en    = '0;
        rsp_next    = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            queue_next[k] = queue_reg[k];
        end
        rsp_next.status = ST_NOT_FOUND;
        case (op_reg)
            CMD_REQUEST:
            begin
                if (used_reg < max_slots_reg)
                begin
                    used_next       = used_reg + 8'd1;
                    rsp_next.status = ST_GRANTED;
                end
                else if (wcount_reg < CNT_W'(QUEUE_DEPTH))
                begin
                    for (int k = 0; k < QUEUE_DEPTH; k++)
                    begin
                        if (CNT_W'(k) == wcount_reg)
                        begin
                            queue_next[k] = id_reg;
                        end
                    end
                    wcount_next     = wcount_reg + CNT_W'(1);
                    rsp_next.status = ST_QUEUED;
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            CMD_RELEASE:
            begin
                if (used_reg == 8'd0)
                begin
                    rsp_next.status = ST_BAD_RELEASE;
                end
                else
                begin
                    rsp_next.status = ST_RELEASED;
                    if ((wcount_reg != '0) && (used_dec < max_slots_reg))
                    begin
                        // Hand the slot to the oldest waiter; the count stays.
                        rsp_next.waiter_granted = 1'b1;
                        rsp_next.waiter_id      = 8'(queue_reg[0]);
                        shift_en                = '1;
                        wcount_next             = wcount_reg - CNT_W'(1);
                    end
                    else
                    begin
                        used_next = used_dec;
                    end
                end
            end
            CMD_CANCEL:
            begin
                if (found)
                begin
                    // Entries at and behind the first match move up one place.
                    for (int k = 0; k < QUEUE_DEPTH - 1; k++)
                    begin
                        shift_en[k] = |(match_reg & QUEUE_DEPTH'((2 ** (k + 1)) - 1));
                    end
                    wcount_next     = wcount_reg - CNT_W'(1);
                    rsp_next.status = ST_CANCELLED;
                end
            end
            default:
            begin
                rsp_next.status = ST_NOT_FOUND;
            end
        endcase
        for (int k = 0; k < QUEUE_DEPTH - 1; k++)
        begin
            if (shift_en[k])
            begin
                queue_next[k] = queue_reg[k + 1];
            end
        end
        rsp_next.slots_in_use = used_next;
    end

    // Queue cells and response payload.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int k = 0; k < QUEUE_DEPTH; k++)
            begin
                queue_reg[k] <= queue_next[k];
            end
            rsp_reg <= rsp_next;
        end
    end

    // Control state: limit register, slot count and queue fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_slots_reg <= 8'd1;
            used_reg      <= 8'd0;
            wcount_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_slots_reg <= cfg_data;
            end
            if (cmd.exec)
            begin
                used_reg   <= used_next;
                wcount_reg <= wcount_next;
            end
        end
    end

    assign rsp = rsp_reg;

endmodule
`default_nettype wire

FILE: hdl/fcs_checker.sv
`default_nettype none
// ============================================================================
// fcs_port_checker
// Port-level checks for the FIFO counting semaphore, bound to the top level.
// ============================================================================
module fcs_port_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire fcs_pkg::rsp_t rsp
);
    import fcs_pkg::*;

    // A stalled response word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // Every accepted word is followed by a busy cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted on back-to-back cycles");

    // Only a release can hand a slot to a waiter.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.waiter_granted |-> rsp.status == ST_RELEASED)
        else $error("waiter granted by a non-release operation");

    // The waiter id is zero when no waiter was granted.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.waiter_granted |-> rsp.waiter_id == 8'd0)
        else $error("waiter id nonzero without a grant");

endmodule

bind fifo_counting_semaphore fcs_port_checker u_fcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
`default_nettype wire

FILE: tb/fcs_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// fcs_checker
// Watches the request, response and slot-limit ports of the FIFO counting
// semaphore. It keeps its own copy of the held-slot count, the wait queue and
// the slot limit. For each accepted request word it predicts the response
// word. Each accepted response word is then compared field by field with the
// oldest prediction.
// ============================================================================
module fcs_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_stall,
    input  wire fcs_pkg::req_t req,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_stall,
    input  wire fcs_pkg::rsp_t rsp,
    input  wire logic          cfg_we,
    input  wire logic [7:0]    cfg_data,
    output int unsigned        fail_count,
    output int unsigned        outstanding
);
    import fcs_pkg::*;

    // Shadow state of the semaphore.
    logic [7:0] slot_limit;
    logic [7:0] held_slots;
    logic [7:0] waiting_ids[$];

    // Predicted response words, oldest first.
    rsp_t       expected_rsp_q[$];
    rsp_t       want;

    // Apply one request word to the shadow state and return its response word.
    function automatic rsp_t semaphore_step(input req_t w);
        rsp_t       r;
        int         pos;
        logic [7:0] id;
        r = '0;
        r.status = ST_NOT_FOUND;
        pos = -1;
        id = w.requester_id & 8'((1 << ID_BITS) - 1);
        case (w.command)
            CMD_REQUEST:
            begin
                if (held_slots < slot_limit)
                begin
                    held_slots++;
                    r.status = ST_GRANTED;
                end
                else if (waiting_ids.size() < QUEUE_DEPTH)
                begin
                    waiting_ids.insert(waiting_ids.size(), id);
                    r.status = ST_QUEUED;
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
            CMD_RELEASE:
            begin
                if (held_slots == 8'd0)
                begin
                    r.status = ST_BAD_RELEASE;
                end
                else
                begin
                    held_slots--;
                    r.status = ST_RELEASED;
                    // Only the oldest waiter gets the freed slot.
                    if (waiting_ids.size() > 0 && held_slots < slot_limit)
                    begin
                        r.waiter_granted = 1'b1;
                        r.waiter_id = waiting_ids[0];
                        waiting_ids.delete(0);
                        held_slots++;
                    end
                end
            end
            CMD_CANCEL:
            begin
                // The oldest matching entry goes; the rest move up.
                for (int k = 0; k < waiting_ids.size(); k++)
                begin
                    if (pos < 0 && waiting_ids[k] == id)
                        pos = k;
                end
                if (pos >= 0)
                begin
                    waiting_ids.delete(pos);
                    r.status = ST_CANCELLED;
                end
            end
            default:
            begin
                // The unused command code changes nothing.
            end
        endcase
        r.slots_in_use = held_slots;
        return r;
    endfunction

    // Response words are checked before the same edge's request is predicted,
    // so a response with nothing waiting is never matched by a new prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_limit = 8'd1;
            held_slots = 8'd0;
            waiting_ids.delete();
            expected_rsp_q.delete();
            outstanding = 0;
            fail_count = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display({"%0t: response word with none expected: ",
                                  "status %0d id %0d used %0d"},
                                 $realtime, rsp.status, rsp.waiter_id, rsp.slots_in_use);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsp_q[0];
                    expected_rsp_q.delete(0);
                    if (rsp.status !== want.status
                        || rsp.waiter_granted !== want.waiter_granted
                        || rsp.waiter_id !== want.waiter_id
                        || rsp.slots_in_use !== want.slots_in_use)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: expected status %0d grant %0d id %0d used %0d, ",
                                      "got status %0d grant %0d id %0d used %0d"},
                                     $realtime, want.status, want.waiter_granted,
                                     want.waiter_id, want.slots_in_use, rsp.status,
                                     rsp.waiter_granted, rsp.waiter_id, rsp.slots_in_use);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_rsp_q.insert(expected_rsp_q.size(), semaphore_step(req));
            if (cfg_we)
                slot_limit = cfg_data;
            outstanding = expected_rsp_q.size();
        end
    end

endmodule

FILE: tb/tb_fifo_counting_semaphore.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_fifo_counting_semaphore
// Drives the FIFO counting semaphore with a short directed sequence and then
// with random phases under several slot limits, with random idle bursts on
// both sides and one long response hold-off. The checker beside the block
// predicts every response word; this module gives the verdict.
// ============================================================================
module tb_fifo_counting_semaphore;
    import fcs_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_data = 8'd0;

    bit          sender_gaps_on = 1'b0;
    bit          receiver_gaps_on = 1'b0;
    bit          long_hold_go = 1'b0;
    int unsigned fail_count;
    int unsigned outstanding;

    logic [7:0]  id_pool[8];
    logic [7:0]  phase_limits[7] = '{8'd255, 8'd2, 8'd1, 8'd5, 8'd0, 8'd16, 8'd3};

    always #5 clk = ~clk;

    fifo_counting_semaphore u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    fcs_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Give up well past the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("fifo_counting_semaphore: mismatch");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_go)
            begin
                long_hold_go = 1'b0;
                rsp_stall = 1'b1;
                repeat (60) @(negedge clk);
                rsp_stall = 1'b0;
            end
            else if (stall_left > 0)
            begin
                rsp_stall = 1'b1;
                stall_left--;
            end
            else if (receiver_gaps_on && $urandom_range(0, 5) == 0)
            begin
                rsp_stall = 1'b1;
                stall_left = $urandom_range(1, 9) - 1;
            end
            else
            begin
                rsp_stall = 1'b0;
            end
        end
    end

    // Offer one request word and hold it until it is accepted.
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] id);
        int gap;
        if (sender_gaps_on && $urandom_range(0, 4) == 0)
        begin
            req_valid = 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge clk);
        end
        req.command = cmd;
        req.requester_id = id;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering words until every response word has come back.
    task automatic wait_drained();
        req_valid = 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Rewrite the slot limit while the block is idle.
    task automatic write_limit(input logic [7:0] limit);
        wait_drained();
        cfg_data = limit;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Random word: mostly requests and releases, cancels that often hit a
    // queued id, and now and then the unused command code.
    task automatic send_random_word();
        int         pick;
        logic [1:0] cmd;
        logic [7:0] id;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            cmd = CMD_REQUEST;
        else if (pick < 75)
            cmd = CMD_RELEASE;
        else if (pick < 95)
            cmd = CMD_CANCEL;
        else
            cmd = 2'b11;
        if ($urandom_range(0, 3) == 0)
            id = 8'($urandom_range(0, 255));
        else
            id = id_pool[$urandom_range(0, 7)];
        send_word(cmd, id);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        sender_gaps_on = 1'b1;
        receiver_gaps_on = 1'b1;

        // Directed part under the reset limit of one slot.
        send_word(CMD_RELEASE, 8'h00);   // nothing held
        send_word(CMD_REQUEST, 8'h00);
        send_word(CMD_REQUEST, 8'hFF);
        send_word(CMD_REQUEST, 8'hAA);
        send_word(CMD_REQUEST, 8'hFF);   // same id queued twice
        send_word(CMD_REQUEST, 8'h55);
        send_word(CMD_CANCEL,  8'hFF);   // only the oldest copy goes
        send_word(CMD_CANCEL,  8'h01);   // not queued
        send_word(2'b11,       8'h80);   // unused command code

        // Raised limit: several waiters eligible, only the oldest is granted.
        write_limit(8'd3);
        send_word(CMD_RELEASE, 8'h00);
        send_word(CMD_REQUEST, 8'h12);
        send_word(CMD_RELEASE, 8'h00);

        // Limit of zero, below the held count: nothing more is granted.
        write_limit(8'd0);
        send_word(CMD_REQUEST, 8'h33);
        send_word(CMD_RELEASE, 8'h00);
        send_word(CMD_RELEASE, 8'h00);
        send_word(CMD_RELEASE, 8'h00);

        // Fill the wait queue past its depth.
        for (int i = 0; i < 18; i++)
            send_word(CMD_REQUEST, 8'($urandom_range(0, 255)));

        // Random phases, one per slot limit.
        foreach (phase_limits[p])
        begin
            foreach (id_pool[j])
                id_pool[j] = 8'($urandom_range(0, 255));
            if (p == 6)
            begin
                sender_gaps_on = 1'b0;
                receiver_gaps_on = 1'b0;
            end
            write_limit(phase_limits[p]);
            if (p == 1)
            begin
                // Long receiver hold-off while words keep coming.
                long_hold_go = 1'b1;
                sender_gaps_on = 1'b0;
                repeat (25) send_random_word();
                sender_gaps_on = 1'b1;
            end
            for (int i = 0; i < 75; i++)
            begin
                if (p == 3 && i == 40)
                    wait_drained();
                send_random_word();
            end
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("fifo_counting_semaphore: match");
        else
            $display("fifo_counting_semaphore: mismatch");
        $finish;
    end

endmodule

FILE: fifo_counting_semaphore.f
hdl/fcs_pkg.sv
hdl/fcs_ctrl.sv
hdl/fcs_datapath.sv
hdl/fifo_counting_semaphore.sv
hdl/fcs_checker.sv
tb/fcs_checker.sv
tb/tb_fifo_counting_semaphore.sv
